// ----- rtl/gda_pkg.sv -----
// Shared constants, types and helper functions of the Gregorian date unit.
package gda_pkg;

    typedef enum logic [2:0] {
        MODE_NEXT  = 3'd0,
        MODE_PREV  = 3'd1,
        MODE_WDAY  = 3'd2,
        MODE_DIFF  = 3'd3,
        MODE_ANNIV = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REG_DAY   = 2'd0,
        REG_MONTH = 2'd1,
        REG_YEAR  = 2'd2
    } reg_idx_t;

    // floor(x/25) = (x*K25) >> S25, high by at most one for x < 2^15
    localparam int unsigned S25 = 20;
    localparam logic [15:0] K25 = 16'd41944;
    // floor(x/7) = (x*K7) >> S7, high by at most one for x < 2^23
    localparam int unsigned S7 = 26;
    localparam logic [23:0] K7 = 24'd9586981;

    localparam logic signed [23:0] COUNT_MAX = 24'sd4194303;

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        unique case (m)
            4'd2:                        r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     r = 5'd30;
            default:                     r = 5'd31;
        endcase
        return r;
    endfunction

    // leap test with y mod 25 by reciprocal multiply
    function automatic logic leap_of(input logic [14:0] y);
        logic [30:0] p;
        logic [10:0] q;
        logic [14:0] qm;
        logic [14:0] r25;
        p   = y * K25;
        q   = p[30:S25];
        qm  = 15'(q * 11'd25);
        if (qm > y) begin
            q  = q - 11'd1;
            qm = 15'(q * 11'd25);
        end
        r25 = y - qm;
        return (y[1:0] == 2'd0) && ((r25 != 15'd0) || (y[3:0] == 4'd0));
    endfunction

endpackage

// ----- rtl/gregorian_date_arithmetic.sv -----
// Top level of the proleptic Gregorian date unit: config registers and result pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  request | in        | in_valid/in_stall  | mode, in_day, in_month, in_year
//  result  | out       | out_valid/out_stall| out_day, out_month, out_year, day_count,
//          |           |                    | weekday, range_error
//  config  | in        | APB psel/penable   | current_day, current_month, current_year
//
//  One transfer per cycle while no held result is stalled by out_stall.
//  The depth is set by the serial-number pipeline (3 stages) and the mod-7 multiply.
//  All stages move together; out_stall with a held result freezes every stage.
//  rst_n clears valid bits and the config registers to 2000-01-01.
module gregorian_date_arithmetic #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic [4:0]         in_day,
    input  logic [3:0]         in_month,
    input  logic [13:0]        in_year,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         out_day,
    output logic [3:0]         out_month,
    output logic [13:0]        out_year,
    output logic signed [22:0] day_count,
    output logic [2:0]         weekday,
    output logic               range_error
);

    localparam logic [16:0] MaxYear = 17'(MAX_YEAR);

    typedef struct packed {
        logic [2:0] mode;
        logic       pre_err;
        logic       mm_gt2;
        logic       leap_next;
        logic       next_ok;
    } side_t;

    logic [4:0]  cur_day_reg;
    logic [3:0]  cur_month_reg;
    logic [13:0] cur_year_reg;

    logic        adv;
    logic        cfg_wr;

    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic [2:0]  mode0_reg;
    logic [4:0]  day0_reg;
    logic [3:0]  month0_reg;
    logic [13:0] year0_reg;

    side_t       side1_next, side1_reg, side2_reg, side3_reg, side4_reg;
    logic        cur_ok, req_ok, mm_ok;
    logic [14:0] cy_plus1;
    logic [13:0] req_year;

    logic [22:0] n_cur, n_req;
    logic        leap_cur, leap_req;

    logic signed [23:0] diff, diff_adj;
    logic               m4_err;
    logic signed [6:0]  t;
    logic [4:0]         len_c, len_p;
    logic [3:0]         pm, nm;
    logic [4:0]         dd_next;
    logic [3:0]         dm_next;
    logic [14:0]        dy_next;
    logic               derr_next;
    logic [22:0]        v7;
    logic [46:0]        p7;

    logic signed [23:0] diff4_reg;
    logic               m4err4_reg;
    logic [4:0]         dd4_reg;
    logic [3:0]         dm4_reg;
    logic [14:0]        dy4_reg;
    logic               derr4_reg;
    logic [22:0]        v74_reg;
    logic [46:0]        p74_reg;

    logic [20:0]        q7;
    logic [22:0]        r7;
    logic signed [23:0] sat;
    logic               sat_err;

    logic [4:0]         od_next;
    logic [3:0]         om_next;
    logic [13:0]        oy_next;
    logic [22:0]        cnt_next;
    logic [2:0]         wd_next;
    logic               err_next;

    logic [4:0]         od_reg;
    logic [3:0]         om_reg;
    logic [13:0]        oy_reg;
    logic [22:0]        cnt_reg;
    logic [2:0]         wd_reg;
    logic               err_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_day_reg   <= 5'd1;
            cur_month_reg <= 4'd1;
            cur_year_reg  <= 14'd2000;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gda_pkg::REG_DAY:   cur_day_reg   <= pwdata[4:0];
                gda_pkg::REG_MONTH: cur_month_reg <= pwdata[3:0];
                gda_pkg::REG_YEAR:  cur_year_reg  <= pwdata[13:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gda_pkg::REG_DAY:   prdata = 32'(cur_day_reg);
            gda_pkg::REG_MONTH: prdata = 32'(cur_month_reg);
            gda_pkg::REG_YEAR:  prdata = 32'(cur_year_reg);
            default:            prdata = 32'd0;
        endcase
    end

    // pipeline control
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // stage 0: request capture
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode0_reg  <= mode;
            day0_reg   <= in_day;
            month0_reg <= in_month;
            year0_reg  <= in_year;
        end
    end

    // stage 1: validity checks alongside the serial pipeline
    always_comb
    begin
        cy_plus1 = {1'b0, cur_year_reg} + 15'd1;
        cur_ok = (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12) &&
                 (cur_year_reg != 14'd0) && (17'(cur_year_reg) <= MaxYear);
        mm_ok  = (month0_reg >= 4'd1) && (month0_reg <= 4'd12);
        req_ok = mm_ok && (year0_reg != 14'd0) && (17'(year0_reg) <= MaxYear);
        side1_next.mode      = mode0_reg;
        side1_next.mm_gt2    = month0_reg > 4'd2;
        side1_next.leap_next = gda_pkg::leap_of(cy_plus1);
        side1_next.next_ok   = 17'(cy_plus1) <= MaxYear;
        unique case (mode0_reg)
            gda_pkg::MODE_NEXT,
            gda_pkg::MODE_PREV:  side1_next.pre_err = !cur_ok;
            gda_pkg::MODE_WDAY:  side1_next.pre_err = !req_ok;
            gda_pkg::MODE_DIFF:  side1_next.pre_err = !cur_ok || !req_ok;
            gda_pkg::MODE_ANNIV: side1_next.pre_err = !cur_ok || !mm_ok;
            default:             side1_next.pre_err = 1'b1;
        endcase
    end

    assign req_year = (mode0_reg == gda_pkg::MODE_ANNIV) ? cur_year_reg : year0_reg;

    gda_serial serial_cur (
        .clk  (clk),
        .en   (adv),
        .d    (cur_day_reg),
        .m    (cur_month_reg),
        .y    (cur_year_reg),
        .n    (n_cur),
        .leap (leap_cur)
    );

    gda_serial serial_req (
        .clk  (clk),
        .en   (adv),
        .d    (day0_reg),
        .m    (month0_reg),
        .y    (req_year),
        .n    (n_req),
        .leap (leap_req)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            side4_reg <= side3_reg;
        end
    end

    // stage 4: difference, anniversary roll, next/previous day, mod-7 multiply
    always_comb
    begin
        diff     = $signed({1'b0, n_req}) - $signed({1'b0, n_cur});
        m4_err   = 1'b0;
        diff_adj = diff;
        // anniversary already passed this year: roll to the next one
        if ((side3_reg.mode == gda_pkg::MODE_ANNIV) && (diff < 24'sd0))
        begin
            if (!side3_reg.next_ok)
            begin
                m4_err = 1'b1;
            end
            else
            begin
                diff_adj = diff + 24'sd365 +
                    $signed({23'd0, side3_reg.mm_gt2 ? side3_reg.leap_next : leap_req});
            end
        end

        t     = $signed({2'b00, cur_day_reg}) +
                ((side3_reg.mode == gda_pkg::MODE_NEXT) ? 7'sd1 : -7'sd1);
        pm    = (cur_month_reg == 4'd1) ? 4'd12 : cur_month_reg - 4'd1;
        nm    = (cur_month_reg == 4'd12) ? 4'd1 : cur_month_reg + 4'd1;
        len_c = gda_pkg::month_len(cur_month_reg, leap_cur);
        len_p = gda_pkg::month_len(pm, leap_cur);
        priority if (t < 7'sd1)
        begin
            dd_next = 5'($signed({2'b00, len_p}) + t);
            dm_next = pm;
            dy_next = (cur_month_reg == 4'd1) ? {1'b0, cur_year_reg} - 15'd1
                                              : {1'b0, cur_year_reg};
        end
        else if (t > $signed({2'b00, len_c}))
        begin
            dd_next = 5'(t - $signed({2'b00, len_c}));
            dm_next = nm;
            dy_next = (cur_month_reg == 4'd12) ? cy_plus1 : {1'b0, cur_year_reg};
        end
        else
        begin
            dd_next = 5'(t);
            dm_next = cur_month_reg;
            dy_next = {1'b0, cur_year_reg};
        end
        derr_next = (dy_next == 15'd0) || (17'(dy_next) > MaxYear);

        v7 = n_req + 23'd6;
        p7 = v7 * gda_pkg::K7;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff4_reg  <= diff_adj;
            m4err4_reg <= m4_err;
            dd4_reg    <= dd_next;
            dm4_reg    <= dm_next;
            dy4_reg    <= dy_next;
            derr4_reg  <= derr_next;
            v74_reg    <= v7;
            p74_reg    <= p7;
        end
    end

    // stage 5: weekday, saturation, field select
    always_comb
    begin
        q7 = p74_reg[46:gda_pkg::S7];
        if (23'(q7 * 23'd7) > v74_reg)
        begin
            q7 = q7 - 21'd1;
        end
        r7 = v74_reg - 23'(q7 * 23'd7);

        sat     = diff4_reg;
        sat_err = 1'b0;
        if (diff4_reg > gda_pkg::COUNT_MAX)
        begin
            sat     = gda_pkg::COUNT_MAX;
            sat_err = 1'b1;
        end
        else if (diff4_reg < -gda_pkg::COUNT_MAX)
        begin
            sat     = -gda_pkg::COUNT_MAX;
            sat_err = 1'b1;
        end

        od_next  = 5'd0;
        om_next  = 4'd0;
        oy_next  = 14'd0;
        cnt_next = 23'd0;
        wd_next  = 3'd0;
        err_next = side4_reg.pre_err;
        unique case (side4_reg.mode)
            gda_pkg::MODE_NEXT,
            gda_pkg::MODE_PREV:
            begin
                if (!side4_reg.pre_err)
                begin
                    if (derr4_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        od_next = dd4_reg;
                        om_next = dm4_reg;
                        oy_next = dy4_reg[13:0];
                    end
                end
            end
            gda_pkg::MODE_WDAY:
            begin
                if (!side4_reg.pre_err)
                begin
                    wd_next = r7[2:0];
                end
            end
            gda_pkg::MODE_DIFF:
            begin
                if (!side4_reg.pre_err)
                begin
                    cnt_next = sat[22:0];
                    err_next = sat_err;
                end
            end
            gda_pkg::MODE_ANNIV:
            begin
                if (!side4_reg.pre_err)
                begin
                    if (m4err4_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = sat[22:0];
                        err_next = sat_err;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            od_reg  <= od_next;
            om_reg  <= om_next;
            oy_reg  <= oy_next;
            cnt_reg <= cnt_next;
            wd_reg  <= wd_next;
            err_reg <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_day     = od_reg;
    assign out_month   = om_reg;
    assign out_year    = oy_reg;
    assign day_count   = $signed(cnt_reg);
    assign weekday     = wd_reg;
    assign range_error = err_reg;

    // a produced date never comes with an error or other fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_day != 5'd0) |-> !range_error && (day_count == 23'sd0) &&
                                           (weekday == 3'd0))
        else $error("date result mixed with other fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weekday <= 3'd6)
        else $error("weekday out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (weekday != 3'd0) |-> !range_error && (out_month == 4'd0))
        else $error("weekday with error or date");

    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v4_reg) && $stable(v0_reg))
        else $error("pipeline moved during stall");

endmodule

// ----- rtl/gda_serial.sv -----
// Three-stage pipelined conversion of a date to its serial day number.
module gda_serial (
    input  logic        clk,
    input  logic        en,
    input  logic [4:0]  d,
    input  logic [3:0]  m,
    input  logic [13:0] y,
    output logic [22:0] n,
    output logic        leap
);

    logic [13:0] ym1;
    logic [11:0] y4;
    logic [27:0] p100;
    logic [29:0] py;

    logic [13:0] ym1_a_reg, y_a_reg;
    logic [11:0] y4_a_reg;
    logic [27:0] p100_a_reg;
    logic [29:0] py_a_reg;
    logic [4:0]  d_a_reg, d_b_reg;
    logic [3:0]  m_a_reg, m_b_reg;

    logic [7:0]  q100e, q100;
    logic [9:0]  qye, qy;
    logic [13:0] r25;
    logic        leap_b_next;

    logic [13:0] ym1_b_reg;
    logic [11:0] y4_b_reg;
    logic [7:0]  q100_b_reg;
    logic        leap_b_reg;

    logic [22:0] n_next;
    logic [22:0] n_reg;
    logic        leap_reg;

    assign ym1  = y - 14'd1;
    assign y4   = ym1[13:2];
    assign p100 = y4 * gda_pkg::K25;
    assign py   = y * gda_pkg::K25;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ym1_a_reg  <= ym1;
            y_a_reg    <= y;
            y4_a_reg   <= y4;
            p100_a_reg <= p100;
            py_a_reg   <= py;
            d_a_reg    <= d;
            m_a_reg    <= m;
        end
    end

    always_comb
    begin
        q100e = p100_a_reg[27:gda_pkg::S25];
        q100  = (12'(q100e * 12'd25) > y4_a_reg) ? q100e - 8'd1 : q100e;
        qye   = py_a_reg[29:gda_pkg::S25];
        qy    = (14'(qye * 14'd25) > y_a_reg) ? qye - 10'd1 : qye;
        r25   = y_a_reg - 14'(qy * 14'd25);
        leap_b_next = (y_a_reg[1:0] == 2'd0) &&
                      ((r25 != 14'd0) || (y_a_reg[3:0] == 4'd0));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ym1_b_reg  <= ym1_a_reg;
            y4_b_reg   <= y4_a_reg;
            q100_b_reg <= q100;
            leap_b_reg <= leap_b_next;
            d_b_reg    <= d_a_reg;
            m_b_reg    <= m_a_reg;
        end
    end

    always_comb
    begin
        n_next = 23'(ym1_b_reg * 23'd365)
               + 23'(y4_b_reg)
               + 23'(q100_b_reg[7:2])
               - 23'(q100_b_reg)
               + 23'(gda_pkg::days_before(m_b_reg))
               + 23'((m_b_reg > 4'd2) && leap_b_reg)
               + 23'(d_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            leap_reg <= leap_b_reg;
        end
    end

    assign n    = n_reg;
    assign leap = leap_reg;

endmodule
